@@ sv/text_console_char_handler_defines.svh @@
// ----------------------------------------------------------------------------
// Text console assertion macros
// Concurrent assertion helpers used by the console sequencer. Defining SYNTH
// turns every use into empty text.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CHAR_HANDLER_DEFINES_SVH
`define TEXT_CONSOLE_CHAR_HANDLER_DEFINES_SVH

`ifndef SYNTH
// Check that a property holds at every clock edge outside reset
`define TCCH_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("text console assertion failed");
// Check that a condition leads to a consequence in the next cycle
`define TCCH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("text console assertion failed");
`else
`define TCCH_ASSERT(lbl, clk, rst_n, prop)
`define TCCH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ sv/tcch_pkg.sv @@
// ----------------------------------------------------------------------------
// Text console package
// Screen geometry, field widths, character codes and shared types.
// ----------------------------------------------------------------------------
package tcch_pkg;

  // Screen geometry
  localparam int COLUMNS   = 80;
  localparam int ROWS      = 25;
  localparam int TAB_WIDTH = 8;
  localparam int CELLS     = COLUMNS * ROWS;

  // Derived widths
  localparam int ADDR_W = $clog2(CELLS);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int PH_W   = $clog2(TAB_WIDTH);

  // Field widths
  localparam int CHAR_W  = 8;
  localparam int ATTR_W  = 7;
  localparam int CELL_W  = CHAR_W + ATTR_W;
  localparam int BG_W    = 3;
  localparam int FG_W    = 4;
  localparam int RROW_W  = 5;
  localparam int RCOL_W  = 7;
  localparam int POS_W   = 11;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_SCROLL     = 8'd1;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE  = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB        = 8'd9;
  localparam logic [CHAR_W-1:0] CH_LINE_FEED  = 8'd10;
  localparam logic [CHAR_W-1:0] CH_FORM_FEED  = 8'd12;
  localparam logic [CHAR_W-1:0] CH_RETURN     = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE      = 8'd32;
  localparam logic [CHAR_W-1:0] CH_PRINT_LAST = 8'd127;

  // Attribute of the screen after reset
  localparam logic [ATTR_W-1:0] RESET_ATTR = 7'h75;

  // Configuration register indexes
  typedef enum logic {
    REG_BACKGROUND = 1'b0,
    REG_FOREGROUND = 1'b1
  } reg_idx_e;

  // Color settings handed to the sequencer
  typedef struct packed {
    logic [BG_W-1:0] bg;
    logic [FG_W-1:0] fg;
  } cfg_t;

  // Screen store access from the sequencer
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

@@ sv/tcch_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tcch_ram #(
  parameter int WIDTH = 15,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and read the array
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/tcch_cfg.sv @@
// ----------------------------------------------------------------------------
// Text console configuration registers
// APB-style access to the background and foreground color registers.
// ----------------------------------------------------------------------------
module tcch_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tcch_pkg::PADDR_W-1:0]  paddr,
  input  logic [tcch_pkg::PDATA_W-1:0]  pwdata,
  output logic [tcch_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output tcch_pkg::cfg_t                cfg_o
);
  import tcch_pkg::*;

  logic [BG_W-1:0] bg_q, bg_d;
  logic [FG_W-1:0] fg_q, fg_d;
  reg_idx_e        idx;
  logic            wr_en;

  assign idx    = reg_idx_e'(paddr[PADDR_W-1]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // Decode writes
  always_comb begin
    bg_d = bg_q;
    fg_d = fg_q;
    if (wr_en) begin
      case (idx)
        REG_BACKGROUND: bg_d = pwdata[BG_W-1:0];
        REG_FOREGROUND: fg_d = pwdata[FG_W-1:0];
        default: ;
      endcase
    end
  end

  // Return register contents
  always_comb begin
    case (idx)
      REG_BACKGROUND: prdata = PDATA_W'(bg_q);
      REG_FOREGROUND: prdata = PDATA_W'(fg_q);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bg_q <= 3'd7;
      fg_q <= 4'd5;
    end else begin
      bg_q <= bg_d;
      fg_q <= fg_d;
    end
  end

  assign cfg_o.bg = bg_q;
  assign cfg_o.fg = fg_q;

endmodule

@@ sv/tcch_seq.sv @@
// ----------------------------------------------------------------------------
// Text console sequencer
// Cursor state and the read-modify-write walks over the screen store:
// cell writes, clear sweeps, scroll copies and cell reads.
// ----------------------------------------------------------------------------
`include "text_console_char_handler_defines.svh"

module tcch_seq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          cmd_i,
  input  logic [tcch_pkg::CHAR_W-1:0]   data_byte_i,
  input  logic [tcch_pkg::RROW_W-1:0]   read_row_i,
  input  logic [tcch_pkg::RCOL_W-1:0]   read_col_i,
  output logic                          done_o,
  output logic [tcch_pkg::POS_W-1:0]    cursor_position_o,
  output logic [tcch_pkg::CHAR_W-1:0]   cell_char_o,
  output logic [tcch_pkg::ATTR_W-1:0]   cell_attribute_o,
  input  tcch_pkg::cfg_t                cfg_i,
  output tcch_pkg::mem_req_t            mem_req_o,
  input  logic [tcch_pkg::CELL_W-1:0]   rdata_i
);
  import tcch_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_CLEAR  = 6'b000010,
    ST_EXEC   = 6'b000100,
    ST_SCROLL = 6'b001000,
    ST_DRAIN  = 6'b010000,
    ST_READ   = 6'b100000
  } state_e;

  localparam logic [COL_W-1:0]  COL_LAST       = COL_W'(COLUMNS - 1);
  localparam logic [COL_W-1:0]  COL_TAB_LIMIT  = COL_W'(COLUMNS - TAB_WIDTH);
  localparam logic [PH_W-1:0]   PH_LAST        = PH_W'(TAB_WIDTH - 1);
  localparam logic [PH_W-1:0]   PH_AT_COL_LAST = PH_W'((COLUMNS - 1) % TAB_WIDTH);
  localparam logic [ROW_W-1:0]  ROW_LAST       = ROW_W'(ROWS - 1);
  localparam logic [ADDR_W-1:0] CNT_LAST       = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] COPY_END       = ADDR_W'(CELLS - COLUMNS);
  localparam logic [ADDR_W-1:0] LINE_OFS       = ADDR_W'(COLUMNS);

  // Control state
  state_e            state_q, state_d;
  logic [ADDR_W-1:0] cnt_q, cnt_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [PH_W-1:0]   ph_q, ph_d;
  logic              cleared_q, cleared_d;
  logic              exec_after_q, exec_after_d;
  logic              wb_valid_q, wb_valid_d;
  logic              done_q, done_d;

  // Payload
  logic [CHAR_W-1:0] byte_q, byte_d;
  logic              in_range_q, in_range_d;
  logic [ADDR_W-1:0] wb_addr_q, wb_addr_d;
  logic              wb_blank_q, wb_blank_d;
  logic [CHAR_W-1:0] char_q, char_d;
  logic [ATTR_W-1:0] attr_q, attr_d;

  logic              accept;
  logic              rd_in_range;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] cur_addr;
  logic [CELL_W-1:0] blank;
  logic              go_scroll;
  logic              go_clear;

  assign accept      = start_i && (state_q == ST_IDLE);
  assign busy_o      = (state_q != ST_IDLE);
  assign blank       = {cfg_i.bg, cfg_i.fg, CH_SPACE};
  assign cur_addr    = ADDR_W'(row_q) * LINE_OFS + ADDR_W'(col_q);
  assign rd_in_range = (int'(read_row_i) < ROWS) && (int'(read_col_i) < COLUMNS);
  assign rd_addr     = rd_in_range ?
                       ADDR_W'(read_row_i) * LINE_OFS + ADDR_W'(read_col_i) : '0;

  // Sequence one item over the screen store
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    col_d        = col_q;
    row_d        = row_q;
    ph_d         = ph_q;
    cleared_d    = cleared_q;
    exec_after_d = exec_after_q;
    wb_valid_d   = 1'b0;
    done_d       = 1'b0;
    byte_d       = byte_q;
    in_range_d   = in_range_q;
    wb_addr_d    = wb_addr_q;
    wb_blank_d   = wb_blank_q;
    char_d       = char_q;
    attr_d       = attr_q;
    go_scroll    = 1'b0;
    go_clear     = 1'b0;

    // Scroll write-back by default; other states take over the port
    mem_req_o.we    = wb_valid_q;
    mem_req_o.waddr = wb_addr_q;
    mem_req_o.wdata = wb_blank_q ? blank : rdata_i;
    mem_req_o.raddr = rd_addr;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          in_range_d = rd_in_range;
          byte_d     = data_byte_i;
          if (cmd_i) begin
            state_d = ST_READ;
          end else if (!cleared_q) begin
            cleared_d    = 1'b1;
            exec_after_d = 1'b1;
            cnt_d        = '0;
            state_d      = ST_CLEAR;
          end else begin
            state_d = ST_EXEC;
          end
        end
      end

      ST_CLEAR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = cnt_q;
        mem_req_o.wdata = blank;
        if (cnt_q == CNT_LAST) begin
          cnt_d = '0;
          if (exec_after_q) begin
            state_d = ST_EXEC;
          end else begin
            done_d  = 1'b1;
            char_d  = '0;
            attr_d  = '0;
            state_d = ST_IDLE;
          end
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      ST_EXEC: begin
        if (byte_q inside {[CH_SPACE:CH_PRINT_LAST]}) begin
          // Store the character and advance
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = cur_addr;
          mem_req_o.wdata = {cfg_i.bg, cfg_i.fg, byte_q};
          if (col_q == COL_LAST) begin
            col_d = '0;
            ph_d  = '0;
            if (row_q == ROW_LAST) begin
              go_scroll = 1'b1;
            end else begin
              row_d = row_q + 1'b1;
            end
          end else begin
            col_d = col_q + 1'b1;
            ph_d  = (ph_q == PH_LAST) ? '0 : ph_q + 1'b1;
          end
        end else begin
          case (byte_q)
            CH_SCROLL: go_scroll = 1'b1;
            CH_BACKSPACE: begin
              if (col_q != '0) begin
                col_d = col_q - 1'b1;
                ph_d  = (ph_q == '0) ? PH_LAST : ph_q - 1'b1;
              end
            end
            CH_TAB: begin
              if (col_q >= COL_TAB_LIMIT) begin
                col_d = COL_LAST;
                ph_d  = PH_AT_COL_LAST;
              end else begin
                col_d = col_q + (COL_W'(TAB_WIDTH) - COL_W'(ph_q));
                ph_d  = '0;
              end
            end
            CH_LINE_FEED: begin
              col_d = '0;
              ph_d  = '0;
              if (row_q == ROW_LAST) begin
                go_scroll = 1'b1;
              end else begin
                row_d = row_q + 1'b1;
              end
            end
            CH_FORM_FEED: begin
              col_d    = '0;
              row_d    = '0;
              ph_d     = '0;
              go_clear = 1'b1;
            end
            CH_RETURN: begin
              col_d = '0;
              ph_d  = '0;
            end
            default: ;
          endcase
        end

        if (go_scroll) begin
          cnt_d   = '0;
          state_d = ST_SCROLL;
        end else if (go_clear) begin
          cnt_d        = '0;
          exec_after_d = 1'b0;
          state_d      = ST_CLEAR;
        end else begin
          done_d  = 1'b1;
          char_d  = '0;
          attr_d  = '0;
          state_d = ST_IDLE;
        end
      end

      ST_SCROLL: begin
        // Read one line ahead, write back in the next cycle
        mem_req_o.raddr = ADDR_W'(cnt_q + LINE_OFS);
        wb_valid_d      = 1'b1;
        wb_addr_d       = cnt_q;
        wb_blank_d      = (cnt_q >= COPY_END);
        if (cnt_q == CNT_LAST) begin
          cnt_d   = '0;
          state_d = ST_DRAIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      ST_DRAIN: begin
        done_d  = 1'b1;
        char_d  = '0;
        attr_d  = '0;
        state_d = ST_IDLE;
      end

      ST_READ: begin
        if (!in_range_q) begin
          char_d = '0;
          attr_d = '0;
        end else if (cleared_q) begin
          char_d = rdata_i[CHAR_W-1:0];
          attr_d = rdata_i[CELL_W-1:CHAR_W];
        end else begin
          char_d = CH_SPACE;
          attr_d = RESET_ATTR;
        end
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      col_q        <= '0;
      row_q        <= '0;
      ph_q         <= '0;
      cleared_q    <= 1'b0;
      exec_after_q <= 1'b0;
      wb_valid_q   <= 1'b0;
      done_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      col_q        <= col_d;
      row_q        <= row_d;
      ph_q         <= ph_d;
      cleared_q    <= cleared_d;
      exec_after_q <= exec_after_d;
      wb_valid_q   <= wb_valid_d;
      done_q       <= done_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    byte_q     <= byte_d;
    in_range_q <= in_range_d;
    wb_addr_q  <= wb_addr_d;
    wb_blank_q <= wb_blank_d;
    char_q     <= char_d;
    attr_q     <= attr_d;
  end

  assign done_o            = done_q;
  assign cursor_position_o = POS_W'(cur_addr);
  assign cell_char_o       = char_q;
  assign cell_attribute_o  = attr_q;

  // Assertions
  `TCCH_ASSERT(a_done_in_idle, clk_i, rst_ni, !done_q || (state_q == ST_IDLE))
  `TCCH_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, accept, state_q != ST_IDLE)
  `TCCH_ASSERT(a_wb_in_scroll, clk_i, rst_ni, !wb_valid_q || (state_q == ST_SCROLL) || (state_q == ST_DRAIN))
  `TCCH_ASSERT(a_no_idle_write, clk_i, rst_ni, !mem_req_o.we || (state_q != ST_IDLE))
  `TCCH_ASSERT(a_cursor_range, clk_i, rst_ni, (int'(row_q) < ROWS) && (int'(col_q) < COLUMNS))

endmodule

@@ sv/text_console_char_handler.sv @@
// ----------------------------------------------------------------------------
// Text console character handler
// Screen store of character cells with a cursor, fed one byte per item.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its one result is on
// the result ports for a single cycle while done_o is high, and the receiver
// cannot stall it. A read, a printable byte or a cursor control code that
// does not scroll or clear goes from idle through ST_READ or ST_EXEC back
// to idle, and busy stays high until it is done. A scroll, whether asked
// for or caused by the cursor running off the last row, and a form feed
// pass every cell through the screen store's one write port, one per cycle.
// The first put after reset first clears the whole store. No clearing pass
// runs after reset; reads before the first put return the reset blank cell.
module text_console_char_handler (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          cmd_i,
  input  logic [tcch_pkg::CHAR_W-1:0]   data_byte_i,
  input  logic                          end_of_call_i,
  input  logic [tcch_pkg::RROW_W-1:0]   read_row_i,
  input  logic [tcch_pkg::RCOL_W-1:0]   read_col_i,
  output logic                          done_o,
  output logic [tcch_pkg::POS_W-1:0]    cursor_position_o,
  output logic [tcch_pkg::CHAR_W-1:0]   cell_char_o,
  output logic [tcch_pkg::ATTR_W-1:0]   cell_attribute_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tcch_pkg::PADDR_W-1:0]  paddr,
  input  logic [tcch_pkg::PDATA_W-1:0]  pwdata,
  output logic [tcch_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import tcch_pkg::*;

  cfg_t              cfg;
  mem_req_t          mem_req;
  logic [CELL_W-1:0] mem_rdata;

  // Color registers
  tcch_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Cursor and screen store sequencing; end_of_call_i is left unconnected
  tcch_seq u_seq (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start),
    .busy_o            (busy),
    .cmd_i             (cmd_i),
    .data_byte_i       (data_byte_i),
    .read_row_i        (read_row_i),
    .read_col_i        (read_col_i),
    .done_o            (done_o),
    .cursor_position_o (cursor_position_o),
    .cell_char_o       (cell_char_o),
    .cell_attribute_o  (cell_attribute_o),
    .cfg_i             (cfg),
    .mem_req_o         (mem_req),
    .rdata_i           (mem_rdata)
  );

  // Screen store
  tcch_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_screen (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

endmodule
